// File: rtl/ppba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppba_pkg: shared types and constants of the power budget allocator
// Record and queue entry layouts, fixed field widths, back end states.
// ----------------------------------------------------------------------------
package ppba_pkg;

  localparam int unsigned PortCountDefault = 8;
  localparam int unsigned PortIdW   = 3;
  localparam int unsigned PowerW    = 8;
  localparam int unsigned SumW      = 11;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QuotW     = 8;
  localparam logic [PowerW-1:0] MaxPowerReset = 8'd100;

  typedef struct packed {
    logic [PortIdW-1:0] port_id;
    logic [PowerW-1:0]  requested;
    logic [PowerW-1:0]  minimum;
    logic               attached;
    logic [PowerW-1:0]  previous;
  } rec_t;

  // One alive port, classified and ready for the budget computation
  typedef struct packed {
    rec_t              rec;
    logic              last;
    logic              over;
    logic [PowerW-1:0] remain;
    logic [SumW-1:0]   req_sum;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } bk_state_e;

endpackage
`default_nettype wire

// File: rtl/ppba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppba_front: record collection and classification
// Store port records, sum attached requests and minimums, then walk the
// stored records and push one classified job per alive port.
// ----------------------------------------------------------------------------
module ppba_front #(
  parameter int unsigned PORT_COUNT = ppba_pkg::PortCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ppba_pkg::PortIdW-1:0]  port_id_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   requested_power_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   minimum_cap_i,
  input  wire logic                          attached_i,
  input  wire logic                          alive_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   previous_budget_i,
  input  wire logic                          final_port_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   device_limit_i,
  output logic                               push_o,
  output ppba_pkg::job_t                     job_o,
  input  wire logic                          full_i
);

  localparam int unsigned CntW = $clog2(PORT_COUNT + 1);
  localparam int unsigned IdxW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  ppba_pkg::rec_t rec_q [PORT_COUNT];

  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               walk_idx_q, walk_idx_d;
  logic                          walk_q, walk_d;
  logic [PORT_COUNT-1:0]         alive_q, alive_d;
  logic [ppba_pkg::SumW-1:0]     req_sum_q, req_sum_d;
  logic [ppba_pkg::SumW-1:0]     min_sum_q, min_sum_d;

  logic            accept;
  logic            room;
  logic            store;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;
  logic            adv;
  logic            walk_done;
  logic            last_alive;
  logic [ppba_pkg::SumW-1:0] max_ext;

  assign accept = start_i && !walk_q;
  assign room   = (count_q < CntW'(PORT_COUNT));
  assign store  = accept && room;
  assign wr_idx = count_q[IdxW-1:0];
  assign rd_idx = walk_idx_q[IdxW-1:0];
  assign busy_o = walk_q;
  assign max_ext = {3'b000, device_limit_i};

  // Dead records are skipped; alive ones wait for space in the queue
  assign adv       = walk_q && (!alive_q[rd_idx] || !full_i);
  assign walk_done = adv && (walk_idx_q == count_q - 1'b1);
  assign push_o    = walk_q && alive_q[rd_idx] && !full_i;

  always_comb begin
    last_alive = 1'b1;
    for (int j = 0; j < PORT_COUNT; j++) begin
      if ((CntW'(j) > walk_idx_q) && alive_q[j]) begin
        last_alive = 1'b0;
      end
    end
  end

  always_comb begin
    job_o.rec     = rec_q[rd_idx];
    job_o.last    = last_alive;
    job_o.over    = (req_sum_q > max_ext);
    job_o.req_sum = req_sum_q;
    job_o.remain  = (min_sum_q < max_ext)
                    ? (device_limit_i - min_sum_q[ppba_pkg::PowerW-1:0]) : '0;
  end

  always_comb begin
    count_d    = count_q;
    walk_idx_d = walk_idx_q;
    walk_d     = walk_q;
    alive_d    = alive_q;
    req_sum_d  = req_sum_q;
    min_sum_d  = min_sum_q;
    if (store) begin
      count_d         = count_q + 1'b1;
      alive_d[wr_idx] = alive_i;
      if (attached_i) begin
        req_sum_d = req_sum_q + {3'b000, requested_power_i};
        min_sum_d = min_sum_q + {3'b000, minimum_cap_i};
      end
    end
    if (accept && final_port_i) begin
      walk_d     = 1'b1;
      walk_idx_d = '0;
    end
    if (adv) begin
      walk_idx_d = walk_idx_q + 1'b1;
    end
    if (walk_done) begin
      walk_d    = 1'b0;
      count_d   = '0;
      alive_d   = '0;
      req_sum_d = '0;
      min_sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      walk_idx_q <= '0;
      walk_q     <= 1'b0;
      alive_q    <= '0;
      req_sum_q  <= '0;
      min_sum_q  <= '0;
    end else begin
      count_q    <= count_d;
      walk_idx_q <= walk_idx_d;
      walk_q     <= walk_d;
      alive_q    <= alive_d;
      req_sum_q  <= req_sum_d;
      min_sum_q  <= min_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      rec_q[wr_idx] <= '{port_id:   port_id_i,
                         requested: requested_power_i,
                         minimum:   minimum_cap_i,
                         attached:  attached_i,
                         previous:  previous_budget_i};
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppba_queue: job queue between front and back end
// Small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
module ppba_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  ppba_pkg::job_t      job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output ppba_pkg::job_t      head_o
);

  localparam int unsigned PtrW = $clog2(ppba_pkg::QueueDepth);
  localparam int unsigned FillW = $clog2(ppba_pkg::QueueDepth + 1);

  ppba_pkg::job_t    mem_q [ppba_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]  fill_q;

  assign full_o  = (fill_q == FillW'(ppba_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppba_back: budget computation and result output
// Pop one job; for an attached port over budget, form the proportional share with
// a serial divider and cap it at the request. Drive one result strobe per job.
// ----------------------------------------------------------------------------
module ppba_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  ppba_pkg::job_t                     head_i,
  output logic                               pop_o,
  output logic                               result_valid_o,
  output logic [ppba_pkg::PortIdW-1:0]       out_port_id_o,
  output logic [ppba_pkg::PowerW-1:0]        new_budget_o,
  output logic                               changed_o,
  output logic                               last_result_o
);

  localparam int unsigned ProdW = 2 * ppba_pkg::PowerW;
  localparam int unsigned CntW  = $clog2(ppba_pkg::QuotW);

  ppba_pkg::bk_state_e        state_q, state_d;
  ppba_pkg::job_t             job_q, job_d;
  logic [ppba_pkg::SumW-1:0]  rem_q, rem_d;
  logic [ppba_pkg::QuotW-1:0] quo_q, quo_d;
  logic [CntW-1:0]            cnt_q, cnt_d;

  logic                       valid_d;
  logic [ppba_pkg::PortIdW-1:0] id_d;
  logic [ppba_pkg::PowerW-1:0]  budget_d;
  logic                       changed_d;
  logic                       last_d;
  logic                       valid_q;
  logic [ppba_pkg::PortIdW-1:0] id_q;
  logic [ppba_pkg::PowerW-1:0]  budget_q;
  logic                       changed_q;
  logic                       last_q;

  logic [ProdW-1:0]           prod;
  logic [ppba_pkg::SumW:0]    trial;
  logic                       ge;
  logic [ppba_pkg::PowerW:0]  share_sum;

  assign prod  = head_i.rec.requested * head_i.remain;
  assign trial = {rem_q, quo_q[ppba_pkg::QuotW-1]};
  assign ge    = (trial >= {1'b0, job_q.req_sum});
  assign share_sum = {1'b0, job_q.rec.minimum} + {1'b0, quo_q};

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    valid_d   = 1'b0;
    id_d      = id_q;
    budget_d  = budget_q;
    changed_d = changed_q;
    last_d    = last_q;
    unique case (state_q)
      ppba_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = head_i;
          if (head_i.over && head_i.rec.attached) begin
            // Quotient fits in eight bits, so the upper byte starts below the divisor
            rem_d   = {3'b000, prod[ProdW-1:ppba_pkg::QuotW]};
            quo_d   = prod[ppba_pkg::QuotW-1:0];
            cnt_d   = '0;
            state_d = ppba_pkg::BK_DIV;
          end else begin
            valid_d   = 1'b1;
            id_d      = head_i.rec.port_id;
            budget_d  = head_i.over ? head_i.rec.minimum : head_i.rec.requested;
            changed_d = (budget_d != head_i.rec.previous);
            last_d    = head_i.last;
          end
        end
      end
      ppba_pkg::BK_DIV: begin
        rem_d = ge ? (trial[ppba_pkg::SumW-1:0] - job_q.req_sum) : trial[ppba_pkg::SumW-1:0];
        quo_d = {quo_q[ppba_pkg::QuotW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ppba_pkg::QuotW - 1)) begin
          state_d = ppba_pkg::BK_FIN;
        end
      end
      ppba_pkg::BK_FIN: begin
        valid_d   = 1'b1;
        id_d      = job_q.rec.port_id;
        budget_d  = (share_sum < {1'b0, job_q.rec.requested})
                    ? share_sum[ppba_pkg::PowerW-1:0] : job_q.rec.requested;
        changed_d = (budget_d != job_q.rec.previous);
        last_d    = job_q.last;
        state_d   = ppba_pkg::BK_IDLE;
      end
      default: state_d = ppba_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppba_pkg::BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    id_q      <= id_d;
    budget_q  <= budget_d;
    changed_q <= changed_d;
    last_q    <= last_d;
  end

  assign result_valid_o = valid_q;
  assign out_port_id_o  = id_q;
  assign new_budget_o   = budget_q;
  assign changed_o      = changed_q;
  assign last_result_o  = last_q;

endmodule
`default_nettype wire

// File: rtl/proportional_power_budget_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_power_budget_allocator: per-port power budgets
// Collects one record per port, then hands out a budget for each alive port
// in arrival order, proportional to the requests when the device is over
// budget; an attached port gets its minimum plus a share, up to its request.
// ----------------------------------------------------------------------------
// Drive one port record per start transaction while busy is low; the record
// with final_port_i set closes the set. After the final record, busy stays
// high while the stored records are walked and the alive ones are queued,
// and it stays high longer while the four-entry job queue is full. Results
// follow, one per alive port, each as a single-cycle pulse on result_valid_o
// that cannot be held off: the receiver must take every result in the cycle
// it appears. A result for a port that is within budget, or detached, is
// registered straight from the queue head; an attached port in the
// over-budget case first passes the eight-step serial divider that forms
// request * remainder / request sum. The next set of records may be sent as
// soon as busy drops, while results of the previous set still drain. Write
// the device power limit through the cfg channel only while no set is in
// flight; it is always ready.
// ----------------------------------------------------------------------------
module proportional_power_budget_allocator #(
  parameter int unsigned PORT_COUNT = ppba_pkg::PortCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Record input
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ppba_pkg::PortIdW-1:0]  port_id_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   requested_power_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   minimum_cap_i,
  input  wire logic                          attached_i,
  input  wire logic                          alive_i,
  input  wire logic [ppba_pkg::PowerW-1:0]   previous_budget_i,
  input  wire logic                          final_port_i,
  // Configuration write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ppba_pkg::PowerW-1:0]   cfg_data_i,
  // Results
  output logic                               result_valid_o,
  output logic [ppba_pkg::PortIdW-1:0]       out_port_id_o,
  output logic [ppba_pkg::PowerW-1:0]        new_budget_o,
  output logic                               changed_o,
  output logic                               last_result_o
);

  logic [ppba_pkg::PowerW-1:0] device_limit_q;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  ppba_pkg::job_t q_job;
  ppba_pkg::job_t q_head;

  // Budget register: always ready; the user must write it only between sets, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_limit_q <= ppba_pkg::MaxPowerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      device_limit_q <= cfg_data_i;
    end
  end

  // Front end: store, sum, classify
  ppba_front #(
    .PORT_COUNT (PORT_COUNT)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_o            (busy),
    .port_id_i         (port_id_i),
    .requested_power_i (requested_power_i),
    .minimum_cap_i     (minimum_cap_i),
    .attached_i        (attached_i),
    .alive_i           (alive_i),
    .previous_budget_i (previous_budget_i),
    .final_port_i      (final_port_i),
    .device_limit_i    (device_limit_q),
    .push_o            (q_push),
    .job_o             (q_job),
    .full_i            (q_full)
  );

  // Decouple the walk from the divider
  ppba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back end: compute budget and emit
  ppba_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .out_port_id_o  (out_port_id_o),
    .new_budget_o   (new_budget_o),
    .changed_o      (changed_o),
    .last_result_o  (last_result_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && final_port_i))
    else $error("walk started without a final record");
`endif

endmodule
`default_nettype wire

// File: test/proportional_power_budget_allocator_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_power_budget_allocator_test: self-checking bench for the allocator
// Sends sets of port records through the start/busy handshake and predicts
// the budget of every alive port. Each result strobe is checked field by field
// against the oldest prediction. The bench runs a directed part at the reset
// power limit, then random sets under several power limits, with random
// idle gaps on the record side and one phase that never idles.
// ----------------------------------------------------------------------------
module proportional_power_budget_allocator_test;
  localparam int unsigned PortIdW = ppba_pkg::PortIdW;
  localparam int unsigned PowerW  = ppba_pkg::PowerW;
  localparam int unsigned SumW    = ppba_pkg::SumW;

  localparam int unsigned PORTS = 8;
  // Cycles with no transaction at all before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to let the block finish its walk once no result is outstanding
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct {
    logic [PortIdW-1:0] port;
    logic [PowerW-1:0]  req;
    logic [PowerW-1:0]  minimum;
    logic               att;
    logic               alive;
    logic [PowerW-1:0]  prev;
    logic               fin;
    int unsigned        gap;     // idle cycles on start before this record
  } port_rec_t;

  typedef struct {
    logic [PortIdW-1:0] port;
    logic [PowerW-1:0]  budget;
    logic               changed;
    logic               last;
  } budget_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic [PortIdW-1:0] port_id_i = '0;
  logic [PowerW-1:0]  requested_power_i = '0;
  logic [PowerW-1:0]  minimum_cap_i = '0;
  logic               attached_i = 1'b0;
  logic               alive_i = 1'b0;
  logic [PowerW-1:0]  previous_budget_i = '0;
  logic               final_port_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [PowerW-1:0]  cfg_data_i = '0;
  logic               result_valid_o;
  logic [PortIdW-1:0] out_port_id_o;
  logic [PowerW-1:0]  new_budget_o;
  logic               changed_o;
  logic               last_result_o;

  // Records waiting to be sent, and budgets waiting to come back
  port_rec_t record_q[$];
  budget_t   budget_q[$];

  // Shadow of the block: configured limit, records of the open set, sums
  logic [PowerW-1:0] power_limit = ppba_pkg::MaxPowerReset;
  port_rec_t         held_recs[PORTS];
  int unsigned       held_count = 0;
  logic [SumW-1:0]   request_total = '0;
  logic [SumW-1:0]   minimum_total = '0;

  logic        taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  proportional_power_budget_allocator #(
    .PORT_COUNT(PORTS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .port_id_i        (port_id_i),
    .requested_power_i(requested_power_i),
    .minimum_cap_i    (minimum_cap_i),
    .attached_i       (attached_i),
    .alive_i          (alive_i),
    .previous_budget_i(previous_budget_i),
    .final_port_i     (final_port_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .out_port_id_o    (out_port_id_o),
    .new_budget_o     (new_budget_o),
    .changed_o        (changed_o),
    .last_result_o    (last_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Budget of one stored record under the current sums and limit.
  // Within budget every port gets its request; over budget a detached port
  // falls back to its minimum and an attached one gets minimum plus its
  // proportional share of what the minimums leave, capped at the request.
  function automatic logic [PowerW-1:0] grant_for(port_rec_t r);
    logic [PowerW-1:0] remain;
    int unsigned       share;
    int unsigned       grant;
    if (request_total <= SumW'(power_limit)) return r.req;
    if (!r.att) return r.minimum;
    remain = (minimum_total < SumW'(power_limit)) ? PowerW'(SumW'(power_limit) - minimum_total)
                                                  : '0;
    share = (int'(r.req) * int'(remain)) / int'(request_total);
    grant = int'(r.minimum) + share;
    return (grant < int'(r.req)) ? PowerW'(grant) : r.req;
  endfunction

  // Fold one accepted record into the open set; on the final record queue a
  // budget per alive port in arrival order and close the set.
  function automatic void absorb_record(port_rec_t r);
    budget_t run_q[$];
    budget_t b;
    // Once the store is full, further records are dropped, the final one too
    if (held_count < PORTS) begin
      held_recs[held_count] = r;
      held_count++;
      if (r.att) begin
        request_total += SumW'(r.req);
        minimum_total += SumW'(r.minimum);
      end
    end
    if (!r.fin) return;
    for (int i = 0; i < held_count; i++) begin
      if (held_recs[i].alive) begin
        b.port    = held_recs[i].port;
        b.budget  = grant_for(held_recs[i]);
        b.changed = (b.budget != held_recs[i].prev);
        b.last    = 1'b0;
        run_q.push_back(b);
      end
    end
    // A set with no alive port yields no result at all
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) budget_q.push_back(run_q[i]);
    held_count    = 0;
    request_total = '0;
    minimum_total = '0;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic port_rec_t make_rec(int unsigned port, int unsigned req,
                                         int unsigned minimum, bit att, bit alive,
                                         int unsigned prev, bit fin);
    port_rec_t r;
    r.port    = PortIdW'(port);
    r.req     = PowerW'(req);
    r.minimum = PowerW'(minimum);
    r.att     = att;
    r.alive   = alive;
    r.prev    = PowerW'(prev);
    r.fin     = fin;
    r.gap     = 0;
    return r;
  endfunction

  function automatic port_rec_t rand_rec(bit quiet);
    port_rec_t r;
    r.port = PortIdW'($urandom_range(PORTS - 1));
    // Mix small and near-full requests so both budget branches get hit often
    case ($urandom_range(3))
      0: r.req = PowerW'($urandom_range(255));
      1: r.req = PowerW'($urandom_range(40));
      2: r.req = PowerW'($urandom_range(255, 200));
      default: r.req = PowerW'($urandom_range(100));
    endcase
    r.minimum = ($urandom_range(3) == 0) ? PowerW'($urandom_range(255))
                                          : PowerW'($urandom_range(30));
    r.att   = ($urandom_range(99) < 80);
    r.alive = ($urandom_range(99) < 85);
    // Previous budget often equals a likely outcome, so changed takes both values
    case ($urandom_range(2))
      0: r.prev = r.req;
      1: r.prev = r.minimum;
      default: r.prev = PowerW'($urandom_range(255));
    endcase
    r.fin = 1'b0;
    r.gap = (quiet || $urandom_range(99) >= 4) ? 0 : $urandom_range(5, 1);
    return r;
  endfunction

  // Queue one set of records; the last one closes the set
  task automatic queue_set(int unsigned size, bit quiet);
    port_rec_t r;
    for (int i = 0; i < size; i++) begin
      r = rand_rec(quiet);
      r.fin = (i == size - 1);
      record_q.push_back(r);
    end
  endtask

  // Hold until every record is sent, every budget is back and the block is quiet
  task automatic drain();
    while (record_q.size() != 0 || start || budget_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_device_limit(logic [PowerW-1:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Record driver: update on the falling edge, hold a record until the
  // transaction completes, then idle for the next record's gap or move on.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !taken) begin
        // hold the current record
      end else if (record_q.size() != 0 && record_q[0].gap != 0) begin
        start <= 1'b0;
        record_q[0].gap--;
      end else if (record_q.size() != 0) begin
        port_id_i         <= record_q[0].port;
        requested_power_i <= record_q[0].req;
        minimum_cap_i     <= record_q[0].minimum;
        attached_i        <= record_q[0].att;
        alive_i           <= record_q[0].alive;
        previous_budget_i <= record_q[0].prev;
        final_port_i      <= record_q[0].fin;
        start             <= 1'b1;
        void'(record_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge, feed accepted records and register
  // writes to the shadow, check every result strobe, and watch for a hang.
  always @(posedge clk_i) begin
    port_rec_t r;
    budget_t   want;
    if (rst_ni) begin
      taken <= start && !busy;
      if (start && !busy) begin
        r = make_rec(port_id_i, requested_power_i, minimum_cap_i, attached_i, alive_i,
                     previous_budget_i, final_port_i);
        absorb_record(r);
      end
      if (cfg_valid_i && cfg_ready_o) power_limit = cfg_data_i;
      if (result_valid_o) begin
        if (budget_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual port %0d budget %0d",
                   $time, out_port_id_o, new_budget_o);
          mismatches++;
        end else begin
          want = budget_q.pop_front();
          check_field("out_port_id", want.port, out_port_id_o);
          check_field("new_budget", want.budget, new_budget_o);
          check_field("changed", want.changed, changed_o);
          check_field("last_result", want.last, last_result_o);
        end
      end
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d budgets still outstanding", $time, budget_q.size());
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [PowerW-1:0] limits[5];
    int unsigned       sent;
    int unsigned       size;
    limits[0] = '0;
    limits[1] = '1;
    limits[2] = PowerW'(1);
    limits[3] = PowerW'($urandom_range(255));
    limits[4] = PowerW'(60);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets at the reset limit of 100 W.
    // Within budget: each port gets its request, detached ones too.
    record_q.push_back(make_rec(0, 30, 10, 1, 1, 30, 0));
    record_q.push_back(make_rec(7, 40, 0, 1, 1, 0, 0));
    record_q.push_back(make_rec(3, 255, 255, 0, 1, 255, 1));
    // Over budget with some headroom above the minimums; dead final record
    record_q.push_back(make_rec(1, 255, 90, 1, 1, 0, 0));
    record_q.push_back(make_rec(2, 10, 0, 1, 1, 255, 0));
    record_q.push_back(make_rec(4, 200, 7, 0, 1, 7, 0));
    record_q.push_back(make_rec(6, 20, 5, 1, 0, 0, 1));
    // Minimum above request: the cap at the request wins
    record_q.push_back(make_rec(0, 5, 60, 1, 1, 60, 0));
    record_q.push_back(make_rec(7, 250, 0, 1, 1, 250, 1));
    // No alive port: the set closes without any result
    record_q.push_back(make_rec(2, 128, 1, 1, 0, 3, 0));
    record_q.push_back(make_rec(5, 64, 2, 0, 0, 4, 1));
    // Too many records: the ninth and later are dropped, the final one too
    for (int i = 0; i < 10; i++) begin
      record_q.push_back(make_rec(i % PORTS, 20, i, 1, i % 2, 20, 0));
    end
    record_q.push_back(make_rec(6, 99, 99, 1, 1, 99, 1));
    // Single record set at the field maximums, minimums eat the whole budget
    record_q.push_back(make_rec(7, 255, 255, 1, 1, 255, 1));
    drain();

    // Random sets, one phase per power limit; the middle one never idles
    foreach (limits[p]) begin
      write_device_limit(limits[p]);
      sent = 0;
      while (sent < 76) begin
        size = ($urandom_range(11) == 0) ? $urandom_range(11, 9) : $urandom_range(PORTS, 1);
        queue_set(size, p == 2);
        sent += size;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
